// ===== design/rlbl_pkg.sv =====
// shared types, constants and defaults of the relay lock board link unit
`timescale 1ns / 1ps
package rlbl_pkg;

  // default sizes
  localparam int RELAYS_DEF       = 128;
  localparam int FRAME_LENGTH_DEF = 83;
  localparam int SIDES_DEF        = 2;

  // field widths
  localparam int FLOOR_W = 7;
  localparam int RELAY_W = 7;

  // board stride in bytes for a floor count of 64: 64 * 2 / 8 + 1
  localparam int FLOOR_MAX  = 64;
  localparam int STRIDE_MAX = FLOOR_MAX * 2 / 8 + 1;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd8;

  // frame bytes
  localparam logic [7:0] HDR_STATUS = 8'hF2;
  localparam logic [7:0] HDR_UNLOCK = 8'hFA;
  localparam logic [7:0] TRL_STATUS = 8'h2F;
  localparam logic [7:0] TRL_UNLOCK = 8'hAF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;

  localparam logic [3:0] MISS_HOLD = 4'd9;
  localparam logic [3:0] MISS_LIMIT = 4'd2;

  // command codes
  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_POLL   = 2'd1;
  localparam logic [1:0] CMD_UNLOCK = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // result kinds
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic               link_side;
    logic [7:0]         rx_byte;
    logic [RELAY_W-1:0] relay_index;
  } rlbl_in_t;

  typedef struct packed {
    logic       kind;
    logic       out_side;
    logic [7:0] tx_byte;
    logic       lock_closed;
    logic       sensor_empty;
    logic       last;
  } rlbl_out_t;

endpackage

// ===== design/rlbl_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module rlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rlbl_div.sv =====
// iterative divider by repeated subtraction, one subtract a cycle
`timescale 1ns / 1ps
module rlbl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rlbl_pkg::RELAY_W-1:0]  dividend,
  input  logic [rlbl_pkg::FLOOR_W-1:0]  divisor,
  output logic                          done,
  output logic [rlbl_pkg::RELAY_W-1:0]  quot,
  output logic [rlbl_pkg::RELAY_W-1:0]  rem
);
  import rlbl_pkg::*;

  logic                busy_r;
  logic [RELAY_W-1:0]  rem_r;
  logic [RELAY_W-1:0]  quot_r;
  logic [FLOOR_W-1:0]  dvs_r;
  logic                fits;

  // remainder still holds another divisor
  assign fits = {1'b0, rem_r} >= {1'b0, dvs_r};
  assign done = busy_r && !fits;
  assign quot = quot_r;
  assign rem  = rem_r;

  // subtract loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      rem_r  <= dividend;
      quot_r <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r  <= rem_r - dvs_r;
        quot_r <= quot_r + 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/relay_lock_board_link_unit.sv =====
// top level: relay lock board link sequencer, one item in flight at a time
// a received byte passes through the rx state; a poll emits 4 result beats;
// an unlock waits for the subtract divider, then emits 6 beats; a query reads
// the status ram, then emits 1 beat; a completed received frame adds a remap walk
// of a read state and a write state per relay before the next item is taken
// reset: synchronous; status reads all ones by cleared valid bits, no clearing pass
`timescale 1ns / 1ps
module relay_lock_board_link_unit #(
  parameter int RELAYS       = rlbl_pkg::RELAYS_DEF,
  parameter int FRAME_LENGTH = rlbl_pkg::FRAME_LENGTH_DEF,
  parameter int SIDES        = rlbl_pkg::SIDES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rlbl_pkg::rlbl_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rlbl_pkg::rlbl_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlbl_pkg::FLOOR_W-1:0]    cfg_data
);
  import rlbl_pkg::*;

  localparam int BODY_LEN = FRAME_LENGTH - 1;
  localparam int DATA_LEN = FRAME_LENGTH - 3;
  localparam int RI_W     = $clog2(RELAYS);
  localparam int IDX_W    = $clog2(RELAYS + 1);
  localparam int SA_W     = $clog2(SIDES * RELAYS);
  localparam int FA_W     = $clog2(SIDES * BODY_LEN);
  localparam int POS_W    = $clog2(FRAME_LENGTH);
  localparam int BASE_W   = $clog2(FRAME_LENGTH + STRIDE_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_DIV, S_QRD, S_QWT, S_EMIT, S_WREQ, S_WWR
  } state_t;

  state_t                    state_r;
  logic [FLOOR_W-1:0]        floor_r;
  logic [1:0]                cmd_r;
  logic                      side_r;
  logic [7:0]                rx_r;
  logic [RELAY_W-1:0]        relay_r;
  logic [2:0]                step_r;
  logic [7:0]                board_r;
  logic [7:0]                slot_num_r;
  logic [1:0]                qbits_r;
  logic [SIDES-1:0][3:0]     miss_r;
  logic [SIDES-1:0][POS_W-1:0] pos_r;
  logic [SIDES-1:0][RELAYS-1:0] valid_r;
  logic [IDX_W-1:0]          wi_r;
  logic [FLOOR_W-1:0]        slot_r;
  logic [BASE_W-1:0]         base_r;
  logic                      in_range_r;
  logic                      out_valid_r;
  rlbl_out_t                 out_data_r;

  logic                      accept;
  logic [FLOOR_W-1:0]        fl_eff;
  logic [BASE_W-1:0]         stride;
  logic [BASE_W-1:0]         widx;
  logic                      walk_end;
  logic [POS_W-1:0]          pos_cur;
  logic [3:0]                miss_cur;
  logic                      emit_fire;
  logic [2:0]                count;
  logic [7:0]                emit_byte;
  logic [1:0]                wbits;

  logic                      div_start;
  logic                      div_done;
  logic [RELAY_W-1:0]        div_quot;
  logic [RELAY_W-1:0]        div_rem;

  logic                      st_we;
  logic [SA_W-1:0]           st_waddr;
  logic [SA_W-1:0]           st_raddr;
  logic [1:0]                st_rdata;
  logic                      fr_we;
  logic [FA_W-1:0]           fr_waddr;
  logic [FA_W-1:0]           fr_raddr;
  logic [7:0]                fr_rdata;

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // walk arithmetic
  assign fl_eff   = (floor_r == '0) ? FLOOR_W'(1) : floor_r;
  assign stride   = BASE_W'(fl_eff[FLOOR_W-1:2]) + BASE_W'(1);
  assign widx     = base_r + BASE_W'(slot_r[FLOOR_W-1:2]);
  assign walk_end = (wi_r == IDX_W'(RELAYS)) || (base_r >= BASE_W'(DATA_LEN));
  assign wbits    = in_range_r ? 2'(fr_rdata >> {slot_r[1:0], 1'b0}) : 2'b00;

  assign pos_cur  = pos_r[side_r];
  assign miss_cur = miss_r[in_data.link_side];

  // result sequencing
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  always_comb begin
    case (cmd_r)
      CMD_POLL:   count = 3'd4;
      CMD_UNLOCK: count = 3'd6;
      default:    count = 3'd1;
    endcase
  end

  always_comb begin
    emit_byte = BYTE_ZERO;
    if (cmd_r == CMD_POLL) begin
      case (step_r)
        3'd0:    emit_byte = HDR_STATUS;
        3'd1:    emit_byte = BYTE_ZERO;
        3'd2:    emit_byte = BYTE_ONES;
        default: emit_byte = TRL_STATUS;
      endcase
    end else if (cmd_r == CMD_UNLOCK) begin
      case (step_r)
        3'd0:    emit_byte = HDR_UNLOCK;
        3'd1:    emit_byte = board_r;
        3'd2:    emit_byte = slot_num_r;
        3'd3:    emit_byte = ~board_r;
        3'd4:    emit_byte = ~slot_num_r;
        default: emit_byte = TRL_UNLOCK;
      endcase
    end
  end

  // ram ports
  assign st_we    = (state_r == S_WWR);
  assign st_waddr = SA_W'(int'(side_r) * RELAYS + int'(wi_r));
  assign st_raddr = SA_W'(int'(side_r) * RELAYS + int'(relay_r));
  assign fr_we    = (state_r == S_RX) && (pos_cur != '0);
  assign fr_waddr = FA_W'(int'(side_r) * BODY_LEN + int'(pos_cur) - 1);
  assign fr_raddr = FA_W'(int'(side_r) * BODY_LEN + int'(widx));

  assign div_start = accept && (in_data.command == CMD_UNLOCK) && (int'(in_data.link_side) < SIDES);

  rlbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.relay_index),
    .divisor  (fl_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rlbl_ram #(.WIDTH(2), .DEPTH(SIDES * RELAYS)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (wbits),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rlbl_ram #(.WIDTH(8), .DEPTH(SIDES * BODY_LEN)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (rx_r),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // sequencer, link state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      floor_r     <= FLOOR_RESET;
      miss_r      <= '0;
      pos_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        floor_r <= cfg_data;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept && int'(in_data.link_side) < SIDES) begin
            cmd_r   <= in_data.command;
            side_r  <= in_data.link_side;
            rx_r    <= in_data.rx_byte;
            relay_r <= in_data.relay_index;
            step_r  <= '0;
            case (in_data.command)
              CMD_RX:     state_r <= S_RX;
              CMD_POLL: begin
                if (miss_cur < MISS_HOLD) begin
                  if (miss_cur + 4'd1 == MISS_LIMIT) begin
                    miss_r[in_data.link_side]  <= MISS_HOLD;
                    valid_r[in_data.link_side] <= '0;
                  end else begin
                    miss_r[in_data.link_side] <= miss_cur + 4'd1;
                  end
                end
                state_r <= S_EMIT;
              end
              CMD_UNLOCK: state_r <= S_DIV;
              default:    state_r <= S_QRD;
            endcase
          end
        end
        // header hunt, body byte store, or start of the remap walk at frame end
        S_RX: begin
          if (pos_cur == '0) begin
            if (rx_r == HDR_STATUS) begin
              pos_r[side_r] <= POS_W'(1);
            end
            state_r <= S_IDLE;
          end else if (int'(pos_cur) + 1 > BODY_LEN) begin
            pos_r[side_r]  <= '0;
            miss_r[side_r] <= '0;
            wi_r           <= '0;
            slot_r         <= '0;
            base_r         <= '0;
            state_r        <= S_WREQ;
          end else begin
            pos_r[side_r] <= pos_cur + POS_W'(1);
            state_r       <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            board_r    <= 8'(div_quot) + 8'd1;
            slot_num_r <= 8'(div_rem) + 8'd1;
            state_r    <= S_EMIT;
          end
        end
        S_QRD: state_r <= S_QWT;
        S_QWT: begin
          if (int'(relay_r) < RELAYS && valid_r[side_r][RI_W'(relay_r)]) begin
            qbits_r <= st_rdata;
          end else begin
            qbits_r <= 2'b11;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_data_r.kind         <= (cmd_r == CMD_QUERY) ? KIND_QUERY : KIND_TX;
            out_data_r.out_side     <= side_r;
            out_data_r.tx_byte      <= emit_byte;
            out_data_r.lock_closed  <= (cmd_r == CMD_QUERY) && qbits_r[0];
            out_data_r.sensor_empty <= (cmd_r == CMD_QUERY) && qbits_r[1];
            out_data_r.last         <= (step_r == count - 3'd1);
            step_r                  <= step_r + 3'd1;
            if (step_r == count - 3'd1) begin
              state_r <= S_IDLE;
            end
          end
        end
        // remap walk: read frame byte
        S_WREQ: begin
          if (walk_end) begin
            state_r <= S_IDLE;
          end else begin
            in_range_r <= (widx < BASE_W'(BODY_LEN));
            state_r    <= S_WWR;
          end
        end
        // remap walk: store bit pair and advance relay
        S_WWR: begin
          valid_r[side_r][wi_r[RI_W-1:0]] <= 1'b1;
          wi_r <= wi_r + IDX_W'(1);
          if (slot_r + FLOOR_W'(1) == fl_eff) begin
            slot_r <= '0;
            base_r <= base_r + stride;
          end else begin
            slot_r <= slot_r + FLOOR_W'(1);
          end
          state_r <= S_WREQ;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
